// ----- design/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, constants and the segment loader of the I2C register master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   localparam int TICK_WIDTH_DEF = 16;
   localparam int HP_W           = 16;
   localparam int ADDR_W         = 7;
   localparam int BYTE_W         = 8;

   localparam logic [HP_W-1:0] HALF_PERIOD_RST = 16'd100;

   // register indexes of the write port
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_HALF_PERIOD    = 1'b1;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // transaction steps
   localparam logic [2:0] STEP_ADDR   = 3'd1;
   localparam logic [2:0] STEP_REG    = 3'd2;
   localparam logic [2:0] STEP_DATA   = 3'd3;
   localparam logic [2:0] STEP_RSTART = 3'd3;
   localparam logic [2:0] STEP_ADDR_R = 3'd4;
   localparam logic [2:0] STEP_READ   = 3'd5;
   localparam logic [2:0] STEP_MNACK  = 3'd6;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START_A  = 4'd1,
      PH_START_B  = 4'd2,
      PH_WBIT_LO  = 4'd3,
      PH_WBIT_HI  = 4'd4,
      PH_WACK_LO  = 4'd5,
      PH_WACK_HI  = 4'd6,
      PH_RBIT_LO  = 4'd7,
      PH_RBIT_HI  = 4'd8,
      PH_MNACK_LO = 4'd9,
      PH_MNACK_HI = 4'd10,
      PH_STOP_A   = 4'd11,
      PH_STOP_B   = 4'd12
   } phase_type;

   typedef struct packed {
      phase_type         phase;
      logic              load;
      logic [BYTE_W-1:0] data;
   } seg_type;

   typedef struct packed {
      logic              scl_out;
      logic              sda_out;
      logic              sda_drive;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] read_value;
      logic              nack_seen;
   } rsp_type;

   // What the next step of a transaction starts with.
   function automatic seg_type load_segment(
      input logic              op,
      input logic [2:0]        step,
      input logic [ADDR_W-1:0] addr,
      input logic [BYTE_W-1:0] lreg,
      input logic [BYTE_W-1:0] lval
   );
      seg_type           s;
      logic [BYTE_W-1:0] addr_w;
      addr_w  = {addr, 1'b0};
      s.phase = PH_STOP_A;
      s.load  = 1'b0;
      s.data  = '0;
      if (op == OP_WRITE) begin
         unique case (step)
            STEP_ADDR: begin s.phase = PH_WBIT_LO; s.load = 1'b1; s.data = addr_w; end
            STEP_REG:  begin s.phase = PH_WBIT_LO; s.load = 1'b1; s.data = lreg; end
            STEP_DATA: begin s.phase = PH_WBIT_LO; s.load = 1'b1; s.data = lval; end
            default:   s.phase = PH_STOP_A;
         endcase
      end else begin
         unique case (step)
            STEP_ADDR:   begin s.phase = PH_WBIT_LO; s.load = 1'b1; s.data = addr_w; end
            STEP_REG:    begin s.phase = PH_WBIT_LO; s.load = 1'b1; s.data = lreg; end
            STEP_RSTART: s.phase = PH_START_A;
            STEP_ADDR_R: begin
               s.phase = PH_WBIT_LO; s.load = 1'b1; s.data = addr_w | 8'h01;
            end
            STEP_READ:   begin s.phase = PH_RBIT_LO; s.load = 1'b1; s.data = '0; end
            STEP_MNACK:  s.phase = PH_MNACK_LO;
            default:     s.phase = PH_STOP_A;
         endcase
      end
      return s;
   endfunction

endpackage

// ----- design/i2cm_seq.sv -----
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer state and the single-tick step: one registered request in,
// next state and the pin/status response out.
// ----------------------------------------------------------------------------
module i2cm_seq import i2cm_pkg::*; #(
   parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic              start_req,
   input  logic              func,
   input  logic [BYTE_W-1:0] reg_index,
   input  logic [BYTE_W-1:0] write_value,
   input  logic              sda_in,
   input  logic [ADDR_W-1:0] device_address,
   input  logic [HP_W-1:0]   half_period,
   output rsp_type           rsp
);

   localparam int CW = ((TICK_WIDTH > HP_W) ? TICK_WIDTH : HP_W) + 1;
   localparam logic [CW-1:0] CAP = {{(CW-1){1'b0}}, 1'b1} << TICK_WIDTH;

   phase_type               phase_ff, phase_in, ph_e;
   logic [TICK_WIDTH-1:0]   tick_ff, tick_in, tick_e;
   logic [3:0]              bc_ff, bc_in, bc_e, bc_nx;
   logic [2:0]              bs_ff, bs_in, bs_e;
   logic [BYTE_W-1:0]       shift_ff, shift_in, shift_rd;
   logic                    op_ff, op_in;
   logic [BYTE_W-1:0]       lreg_ff, lreg_in, lval_ff, lval_in;
   logic [BYTE_W-1:0]       rbyte_ff, rbyte_in;
   logic                    nack_ff, nack_in;
   logic [CW-1:0]           hp_ext, limit, tick_nx;
   logic                    phase_end, adv, done;
   seg_type                 seg;

   always_comb begin
      ph_e    = phase_ff;
      op_in   = op_ff;
      lreg_in = lreg_ff;
      lval_in = lval_ff;
      nack_in = nack_ff;
      bs_e    = bs_ff;
      bc_e    = bc_ff;
      tick_e  = tick_ff;
      if (phase_ff == PH_IDLE && start_req) begin
         op_in   = func;
         lreg_in = reg_index;
         lval_in = write_value;
         nack_in = 1'b0;
         bs_e    = '0;
         bc_e    = '0;
         tick_e  = '0;
         ph_e    = PH_START_A;
      end

      rsp.scl_out   = 1'b1;
      rsp.sda_out   = 1'b1;
      rsp.sda_drive = 1'b1;
      unique case (ph_e)
         PH_START_B:  rsp.sda_out = 1'b0;
         PH_WBIT_LO:  begin rsp.scl_out = 1'b0; rsp.sda_out = shift_ff[BYTE_W-1]; end
         PH_WBIT_HI:  rsp.sda_out = shift_ff[BYTE_W-1];
         PH_WACK_LO, PH_RBIT_LO: begin rsp.scl_out = 1'b0; rsp.sda_drive = 1'b0; end
         PH_WACK_HI, PH_RBIT_HI: rsp.sda_drive = 1'b0;
         PH_MNACK_LO: rsp.scl_out = 1'b0;
         PH_STOP_A:   begin rsp.scl_out = 1'b0; rsp.sda_out = 1'b0; end
         PH_STOP_B:   rsp.sda_out = 1'b0;
         default: ;
      endcase

      // phase length: zero acts as one, saturates at the counter range
      hp_ext = CW'(half_period);
      if (hp_ext == '0) begin
         limit = {{(CW-1){1'b0}}, 1'b1};
      end else if (hp_ext > CAP) begin
         limit = CAP;
      end else begin
         limit = hp_ext;
      end
      tick_nx   = CW'(tick_e) + {{(CW-1){1'b0}}, 1'b1};
      phase_end = (tick_nx >= limit);

      seg      = load_segment(op_in, bs_e + 3'd1, device_address, lreg_in, lval_in);
      bc_nx    = bc_e + 4'd1;
      shift_rd = {shift_ff[BYTE_W-2:0], sda_in};

      phase_in = ph_e;
      tick_in  = tick_e;
      bc_in    = bc_e;
      bs_in    = bs_e;
      shift_in = shift_ff;
      rbyte_in = rbyte_ff;
      adv      = 1'b0;
      done     = 1'b0;

      if (ph_e != PH_IDLE) begin
         if (phase_end) begin
            tick_in = '0;
            unique case (ph_e)
               PH_START_A:  phase_in = PH_START_B;
               PH_START_B:  adv = 1'b1;
               PH_WBIT_LO:  phase_in = PH_WBIT_HI;
               PH_WBIT_HI: begin
                  shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
                  if (bc_nx[3]) begin
                     bc_in    = '0;
                     phase_in = PH_WACK_LO;
                  end else begin
                     bc_in    = bc_nx;
                     phase_in = PH_WBIT_LO;
                  end
               end
               PH_WACK_LO:  phase_in = PH_WACK_HI;
               PH_WACK_HI: begin
                  if (sda_in) nack_in = 1'b1;
                  adv = 1'b1;
               end
               PH_RBIT_LO:  phase_in = PH_RBIT_HI;
               PH_RBIT_HI: begin
                  shift_in = shift_rd;
                  if (bc_nx[3]) begin
                     rbyte_in = shift_rd;
                     bc_in    = '0;
                     adv      = 1'b1;
                  end else begin
                     bc_in    = bc_nx;
                     phase_in = PH_RBIT_LO;
                  end
               end
               PH_MNACK_LO: phase_in = PH_MNACK_HI;
               PH_MNACK_HI: adv = 1'b1;
               PH_STOP_A:   phase_in = PH_STOP_B;
               PH_STOP_B: begin
                  phase_in = PH_IDLE;
                  bs_in    = '0;
                  bc_in    = '0;
                  done     = 1'b1;
               end
               default:     phase_in = PH_IDLE;
            endcase
            if (adv) begin
               bs_in    = bs_e + 3'd1;
               phase_in = seg.phase;
               if (seg.load) begin
                  shift_in = seg.data;
                  bc_in    = '0;
               end
            end
         end else begin
            tick_in = tick_nx[TICK_WIDTH-1:0];
         end
      end

      rsp.busy_res   = (phase_in != PH_IDLE);
      rsp.done_res   = done;
      rsp.read_value = rbyte_in;
      rsp.nack_seen  = nack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bc_ff    <= '0;
         bs_ff    <= '0;
         shift_ff <= '0;
         op_ff    <= OP_WRITE;
         lreg_ff  <= '0;
         lval_ff  <= '0;
         rbyte_ff <= '0;
         nack_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bc_ff    <= bc_in;
         bs_ff    <= bs_in;
         shift_ff <= shift_in;
         op_ff    <= op_in;
         lreg_ff  <= lreg_in;
         lval_ff  <= lval_in;
         rbyte_ff <= rbyte_in;
         nack_ff  <= nack_in;
      end
   end

endmodule

// ----- design/i2c_register_access_master.sv -----
// ----------------------------------------------------------------------------
// i2c_register_access_master
// Tick-driven I2C master for single-register writes and reads.
// A taken request waits in the request register; its response is registered
// when it steps. Throughput: one request (one bus tick) per cycle unless the
// response stalls; the step is one pass of logic between the two registers.
// Reset: sequencer idle (scl and sda high), counters and flags cleared,
// device_address 0, half_period 100.
// ----------------------------------------------------------------------------
module i2c_register_access_master import i2cm_pkg::*; #(
   parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_start_req,
   input  logic              req_func,
   input  logic [BYTE_W-1:0] req_reg_index,
   input  logic [BYTE_W-1:0] req_write_value,
   input  logic              req_sda_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_scl_out,
   output logic              rsp_sda_out,
   output logic              rsp_sda_drive,
   output logic              rsp_busy_res,
   output logic              rsp_done_res,
   output logic [BYTE_W-1:0] rsp_read_value,
   output logic              rsp_nack_seen,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [HP_W-1:0]   csr_wr_data
);

   logic              in_vld_ff, in_vld_in;
   logic              start_ff, func_ff, sda_ff;
   logic [BYTE_W-1:0] reg_ff, val_ff;
   logic              out_vld_ff, out_vld_in;
   rsp_type           rsp_ff, step_rsp;
   logic [ADDR_W-1:0] addr_ff;
   logic [HP_W-1:0]   hp_ff;
   logic              advance, req_take;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         addr_ff    <= '0;
         hp_ff      <= HALF_PERIOD_RST;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_wr_en) begin
            if (csr_index == CSR_DEVICE_ADDRESS) begin
               addr_ff <= csr_wr_data[ADDR_W-1:0];
            end else begin
               hp_ff <= csr_wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         start_ff <= req_start_req;
         func_ff  <= req_func;
         reg_ff   <= req_reg_index;
         val_ff   <= req_write_value;
         sda_ff   <= req_sda_in;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   i2cm_seq #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .step_en        (advance),
      .start_req      (start_ff),
      .func           (func_ff),
      .reg_index      (reg_ff),
      .write_value    (val_ff),
      .sda_in         (sda_ff),
      .device_address (addr_ff),
      .half_period    (hp_ff),
      .rsp            (step_rsp)
   );

   assign rsp_valid      = out_vld_ff;
   assign rsp_scl_out    = rsp_ff.scl_out;
   assign rsp_sda_out    = rsp_ff.sda_out;
   assign rsp_sda_drive  = rsp_ff.sda_drive;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_done_res   = rsp_ff.done_res;
   assign rsp_read_value = rsp_ff.read_value;
   assign rsp_nack_seen  = rsp_ff.nack_seen;

endmodule
